// ===== rtl/wcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard component match package
// Shared constants: wildcard byte codes, command codes, register indexes and widths.
// ----------------------------------------------------------------------------
package wcm_pkg;

  // Pattern bytes with a special meaning.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Configuration register indexes (address bits 4 to 3).
  localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;

  // Register widths.
  localparam int unsigned PatternWidth = 128;
  localparam int unsigned LenRegWidth  = 5;
  localparam int unsigned DataWidth    = 64;
  localparam int unsigned AddrWidth    = 5;

endpackage
`default_nettype wire

// ===== rtl/wcm_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard component match: active-set update
// Bit-parallel next-state logic for the set of active pattern positions,
// including the empty-run closure over '*' bytes and the start set.
// ----------------------------------------------------------------------------
module wcm_step #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned SetWidth    = PATTERN_MAX + 1,
  parameter int unsigned LenWidth    = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic [wcm_pkg::PatternWidth-1:0] pattern_i,
  input  wire logic [LenWidth-1:0]              len_used_i,
  input  wire logic [SetWidth-1:0]              cur_set_i,
  input  wire logic [7:0]                       text_byte_i,
  output logic      [SetWidth-1:0]              next_set_o,
  output logic      [SetWidth-1:0]              start_set_o
);

  logic [PATTERN_MAX-1:0] star_m;
  logic [PATTERN_MAX-1:0] adv_m;
  logic [SetWidth-1:0]    step_set;

  // Position j is reachable from an active position i when bytes i to j-1 are all '*'.
  function automatic logic [SetWidth-1:0] closure(input logic [SetWidth-1:0]    s,
                                                  input logic [PATTERN_MAX-1:0] st);
    logic [SetWidth-1:0] r;
    logic                run;
    begin
      r = '0;
      for (int j = 0; j < int'(SetWidth); j++) begin
        r[j] = s[j];
        run  = 1'b1;
        for (int i = j - 1; i >= 0; i--) begin
          run  = run & st[i];
          r[j] = r[j] | (s[i] & run);
        end
      end
      closure = r;
    end
  endfunction

  // Per-position byte classification against the current text byte.
  always_comb begin
    logic [7:0] pbyte;
    logic       in_use;
    for (int i = 0; i < int'(PATTERN_MAX); i++) begin
      pbyte     = pattern_i[8*i +: 8];
      in_use    = (LenWidth'(i) < len_used_i);
      star_m[i] = in_use && (pbyte == wcm_pkg::STAR_BYTE);
      adv_m[i]  = in_use && (pbyte != wcm_pkg::STAR_BYTE) &&
                  ((pbyte == wcm_pkg::ANY_BYTE) || (pbyte == text_byte_i));
    end
  end

  // A star keeps its position; a matching byte moves one position on.
  assign step_set = (cur_set_i & {1'b0, star_m}) |
                    {cur_set_i[PATTERN_MAX-1:0] & adv_m, 1'b0};

  assign next_set_o  = closure(step_set, star_m);
  assign start_set_o = closure(SetWidth'(1), star_m);

endmodule
`default_nettype wire

// ===== rtl/wildcard_component_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard component match
// Matches a streamed text, one byte per beat, against a configured glob
// pattern of up to PATTERN_MAX bytes with '*' and '?' wildcards.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle, text bytes and end-of-text alike, except
// that an end-of-text beat waits in the input register while the output is full.
// Path: an accepted end-of-text beat passes the input register, then the result
// register. The active-set register updates once per text byte, which sets the rate.
// Reset: pattern registers and length clear to zero, the active set returns
// to the start set, and both pipeline stages are empty.
module wildcard_component_match #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wcm_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [wcm_pkg::DataWidth-1:0]  pwdata,
  output logic      [wcm_pkg::DataWidth-1:0]  prdata,
  output logic                                pready,
  // Input channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           cmd_i,
  input  wire logic [7:0]                     text_byte_i,
  // Output channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                matched_o
);

  localparam int unsigned SetWidth = PATTERN_MAX + 1;
  localparam int unsigned LenWidth = $clog2(PATTERN_MAX + 1);

  // Configuration registers
  logic [63:0]                       pat_low_q;
  logic [63:0]                       pat_high_q;
  logic [wcm_pkg::LenRegWidth-1:0]   pat_len_q;
  logic [1:0]                        reg_idx;
  logic                              cfg_wr;
  logic                              cfg_hit;

  // Pipeline and state
  logic                s1_valid_q, s1_valid_d;
  logic                s1_cmd_q;
  logic [7:0]          s1_byte_q;
  logic                s1_go;
  logic                out_free;
  logic                in_fire;
  logic                out_valid_q, out_valid_d;
  logic                matched_q;
  logic [SetWidth-1:0] active_q;
  logic                fresh_q;
  logic [SetWidth-1:0] cur_set;
  logic [SetWidth-1:0] next_set;
  logic [SetWidth-1:0] start_set;
  logic [LenWidth-1:0] len_used;

  // APB write decode; the register is picked by address bits 4 to 3.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      wcm_pkg::REG_PATTERN_LOW:  cfg_hit = 1'b1;
      wcm_pkg::REG_PATTERN_HIGH: cfg_hit = 1'b1;
      wcm_pkg::REG_PATTERN_LEN:  cfg_hit = 1'b1;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        wcm_pkg::REG_PATTERN_LOW:  pat_low_q  <= pwdata;
        wcm_pkg::REG_PATTERN_HIGH: pat_high_q <= pwdata;
        wcm_pkg::REG_PATTERN_LEN:  pat_len_q  <= pwdata[wcm_pkg::LenRegWidth-1:0];
        default: ;
      endcase
    end
  end

  // APB read-back.
  always_comb begin
    unique case (reg_idx)
      wcm_pkg::REG_PATTERN_LOW:  prdata = pat_low_q;
      wcm_pkg::REG_PATTERN_HIGH: prdata = pat_high_q;
      wcm_pkg::REG_PATTERN_LEN:  prdata = wcm_pkg::DataWidth'(pat_len_q);
      default:                   prdata = '0;
    endcase
  end

  // Length in use, capped at the pattern capacity.
  assign len_used = (pat_len_q > wcm_pkg::LenRegWidth'(PATTERN_MAX)) ?
                    LenWidth'(PATTERN_MAX) : LenWidth'(pat_len_q);

  // Handshake: the input stage only stalls on an end-of-text beat with a full output.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && ((s1_cmd_q == wcm_pkg::CMD_BYTE) || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= cmd_i;
      s1_byte_q <= text_byte_i;
    end
  end

  // The current set is the start set until the first byte of a string.
  assign cur_set = fresh_q ? start_set : active_q;

  wcm_step #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_step (
    .pattern_i   ({pat_high_q, pat_low_q}),
    .len_used_i  (len_used),
    .cur_set_i   (cur_set),
    .text_byte_i (s1_byte_q),
    .next_set_o  (next_set),
    .start_set_o (start_set)
  );

  // Active-set register; a write to a pattern or length register, or an end of text, restarts the string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= 1'b1;
      active_q <= '0;
    end else if (cfg_wr && cfg_hit) begin
      fresh_q  <= 1'b1;
    end else if (s1_go) begin
      if (s1_cmd_q == wcm_pkg::CMD_BYTE) begin
        fresh_q  <= 1'b0;
        active_q <= next_set;
      end else begin
        fresh_q  <= 1'b1;
      end
    end
  end

  // Result register.
  assign out_valid_d = (s1_go && (s1_cmd_q == wcm_pkg::CMD_END)) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && (s1_cmd_q == wcm_pkg::CMD_END)) begin
      matched_q <= cur_set[len_used];
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // The input side stalls only behind an end-of-text beat facing a full output.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && (s1_cmd_q == wcm_pkg::CMD_END) &&
                     out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked end-of-text beat");

  // A new result only comes from an end-of-text beat leaving the input stage.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |->
      $past(s1_valid_q && (s1_cmd_q == wcm_pkg::CMD_END)))
    else $error("result appeared without an end-of-text beat");

  // A register write always restarts the string from the start set.
  a_cfg_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_hit) |=> fresh_q)
    else $error("configuration write did not restart the active set");

  // A pending result is not lost while it waits for the consumer.
  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(matched_q)))
    else $error("stalled result changed or was dropped");

endmodule
`default_nettype wire
